### hw/rtl/sbcs_pkg.sv
`default_nettype none

package sbcs_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned CfgIdxW = 3;

  // run-time register indexes
  localparam logic [CfgIdxW-1:0] REG_INHALE_END      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INHALE_HOLD_END = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_EXHALE_END      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_EXHALE_HOLD_END = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INHALE_HP       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_EXHALE_HP       = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_STEP_RES        = 3'd6;

  // sequencer mode codes; the unused code behaves as run
  localparam logic [1:0] MODE_SEEK    = 2'd0;
  localparam logic [1:0] MODE_BACKOFF = 2'd1;
  localparam logic [1:0] MODE_RUN     = 2'd2;

  // reported phase codes
  localparam logic [2:0] PH_SEEK        = 3'd0;
  localparam logic [2:0] PH_BACKOFF     = 3'd1;
  localparam logic [2:0] PH_INHALE      = 3'd2;
  localparam logic [2:0] PH_INHALE_HOLD = 3'd3;
  localparam logic [2:0] PH_EXHALE      = 3'd4;
  localparam logic [2:0] PH_EXHALE_HOLD = 3'd5;
  localparam logic [2:0] PH_PAUSE       = 3'd6;

  typedef struct packed {
    logic [CntW-1:0] inhale_end;
    logic [CntW-1:0] inhale_hold_end;
    logic [CntW-1:0] exhale_end;
    logic [CntW-1:0] exhale_hold_end;
    logic [CntW-1:0] inhale_hp;
    logic [CntW-1:0] exhale_hp;
    logic [2:0]      step_res;
  } cfg_t;

  typedef struct packed {
    logic            step_request;
    logic            direction;
    logic [CntW-1:0] half_period_us;
    logic [2:0]      phase;
    logic [2:0]      microstep_pins;
  } res_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [CntW-1:0] cycle_count;
    logic [CntW-1:0] backoff_left;
  } seq_state_t;

  // microstep mode to MS3..MS1 pin code
  function automatic logic [2:0] ms_code(input logic [2:0] res);
    logic [2:0] code;
    case (res)
      3'd1:    code = 3'd1;
      3'd2:    code = 3'd2;
      3'd3:    code = 3'd3;
      3'd4:    code = 3'd7;
      default: code = 3'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/stepper_breath_cycle_sequencer.sv
`default_nettype none

// Stepper homing and reciprocating cycle sequencer. Each input transfer is one
// motion tick carrying the home-switch level and yields exactly one result
// transfer with the step request, direction, half-period, phase and microstep
// pin code. One tick is taken every clock cycle while in_stall is low: the
// sequencer state and the threshold compares are combinational and the result
// is registered. A two-entry output buffer lets a tick be taken
// while one result is still stalled; in_stall rises only when both entries
// hold results. Configuration writes are registered and must be made while
// no tick is in flight.
module stepper_breath_cycle_sequencer #(
  parameter int unsigned BACKOFF_STEPS = 200,
  parameter int unsigned HOMING_HALF_PERIOD_US = 500
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [sbcs_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [sbcs_pkg::CntW-1:0]    cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_switch_level,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_step_request,
  output logic                              out_direction,
  output logic [sbcs_pkg::CntW-1:0]         out_half_period_us,
  output logic [2:0]                        out_phase,
  output logic [2:0]                        out_microstep_pins
);
  import sbcs_pkg::*;

  localparam logic [CntW-1:0] BackoffLoad = CntW'(BACKOFF_STEPS - 1);
  localparam logic [CntW-1:0] HomeHalfPeriod = CntW'(HOMING_HALF_PERIOD_US);

  cfg_t       cfg_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  res_t       res_nxt;
  res_t       out_r;
  res_t       skid_r;
  logic       out_valid_r;
  logic       skid_valid_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !skid_valid_r;
  assign out_xfer = out_valid_r && !out_stall;

  sbcs_step_logic #(
    .BackoffLoad(BackoffLoad),
    .HomeHalfPeriod(HomeHalfPeriod)
  ) u_step (
    .cur(st_r),
    .switch_level(in_switch_level),
    .cfg(cfg_r),
    .nxt(st_nxt),
    .res(res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inhale_end      <= 16'd200;
      cfg_r.inhale_hold_end <= 16'd300;
      cfg_r.exhale_end      <= 16'd500;
      cfg_r.exhale_hold_end <= 16'd600;
      cfg_r.inhale_hp       <= 16'd500;
      cfg_r.exhale_hp       <= 16'd500;
      cfg_r.step_res        <= 3'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INHALE_END:      cfg_r.inhale_end      <= cfg_wdata;
        REG_INHALE_HOLD_END: cfg_r.inhale_hold_end <= cfg_wdata;
        REG_EXHALE_END:      cfg_r.exhale_end      <= cfg_wdata;
        REG_EXHALE_HOLD_END: cfg_r.exhale_hold_end <= cfg_wdata;
        REG_INHALE_HP:       cfg_r.inhale_hp       <= cfg_wdata;
        REG_EXHALE_HP:       cfg_r.exhale_hp       <= cfg_wdata;
        REG_STEP_RES:        cfg_r.step_res        <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: MODE_SEEK, cycle_count: '0, backoff_left: '0};
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // two-entry result buffer: skid only fills while the head is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_xfer && skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else if (in_xfer && (!out_valid_r || out_xfer)) begin
        out_valid_r <= 1'b1;
      end else if (in_xfer) begin
        skid_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer && skid_valid_r) begin
      out_r <= skid_r;
    end else if (in_xfer && (!out_valid_r || out_xfer)) begin
      out_r <= res_nxt;
    end
    if (in_xfer && out_valid_r && !out_xfer) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_step_request   = out_r.step_request;
  assign out_direction      = out_r.direction;
  assign out_half_period_us = out_r.half_period_us;
  assign out_phase          = out_r.phase;
  assign out_microstep_pins = out_r.microstep_pins;

  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a head result");

  a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled result dropped");

  a_idle_step_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.step_request |-> !out_r.direction && out_r.half_period_us == '0)
    else $error("direction or half-period set without a step");

  a_backoff_left_live: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == MODE_BACKOFF |-> st_r.backoff_left != '0)
    else $error("backing off with no steps left");

  // wrap is taken only when the count is at or past every threshold
  a_wrap_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && st_r.mode == MODE_RUN && in_switch_level &&
      st_r.cycle_count >= cfg_r.inhale_end &&
      st_r.cycle_count >= cfg_r.inhale_hold_end &&
      st_r.cycle_count >= cfg_r.exhale_end &&
      st_r.cycle_count >= cfg_r.exhale_hold_end |=> st_r.cycle_count == 16'd1)
    else $error("wrap did not restart the cycle counter");

endmodule

`default_nettype wire

### hw/rtl/sbcs_step_logic.sv
`default_nettype none

module sbcs_step_logic #(
  parameter logic [15:0] BackoffLoad = 16'd199,
  parameter logic [15:0] HomeHalfPeriod = 16'd500
) (
  input  sbcs_pkg::seq_state_t cur,
  input  logic                 switch_level,
  input  sbcs_pkg::cfg_t       cfg,
  output sbcs_pkg::seq_state_t nxt,
  output sbcs_pkg::res_t       res
);
  import sbcs_pkg::*;

  logic [CntW-1:0] bo_dec;
  logic [CntW-1:0] cnt_base;

  assign bo_dec = (cur.backoff_left != '0) ? cur.backoff_left - 1'b1 : cur.backoff_left;

  always_comb begin
    nxt = cur;
    res = '0;
    res.phase = PH_PAUSE;
    res.microstep_pins = ms_code(cfg.step_res);
    cnt_base = cur.cycle_count;
    unique case (cur.mode)
      MODE_SEEK: begin
        res.step_request = 1'b1;
        res.half_period_us = HomeHalfPeriod;
        if (switch_level) begin
          res.direction = 1'b1;
          res.phase = PH_SEEK;
        end else begin
          res.phase = PH_BACKOFF;
          nxt.backoff_left = BackoffLoad;
          nxt.mode = (BackoffLoad == '0) ? MODE_RUN : MODE_BACKOFF;
        end
      end
      MODE_BACKOFF: begin
        res.step_request = 1'b1;
        res.half_period_us = HomeHalfPeriod;
        res.phase = PH_BACKOFF;
        nxt.backoff_left = bo_dec;
        if (bo_dec == '0) begin
          nxt.mode = MODE_RUN;
        end
      end
      default: begin
        if (switch_level) begin
          if (cur.cycle_count < cfg.inhale_end) begin
            res.step_request = 1'b1;
            res.direction = 1'b1;
            res.half_period_us = cfg.inhale_hp;
            res.phase = PH_INHALE;
          end else if (cur.cycle_count < cfg.inhale_hold_end) begin
            res.phase = PH_INHALE_HOLD;
          end else if (cur.cycle_count < cfg.exhale_end) begin
            res.step_request = 1'b1;
            res.half_period_us = cfg.exhale_hp;
            res.phase = PH_EXHALE;
          end else if (cur.cycle_count < cfg.exhale_hold_end) begin
            res.phase = PH_EXHALE_HOLD;
          end else begin
            // wrap: counter restarts and ends the tick at one
            cnt_base = '0;
          end
          nxt.cycle_count = cnt_base + 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire
